/* rtl/core/secded_pkg.sv */
package secded_pkg;

   // opcode codes carried in req_tuser
   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam int DataWidth = 11;
   localparam int CodeWidth = 16;
   localparam int SynWidth  = 4;

   // code word positions of data bits d0..d10
   localparam logic [3:0] DataPos [DataWidth] = '{
      4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
   };

   // decode status codes
   typedef enum logic [1:0] {
      STAT_NONE   = 2'd0,
      STAT_SINGLE = 2'd1,
      STAT_PARITY = 2'd2,
      STAT_DOUBLE = 2'd3
   } status_type;

   // entry stage payload: opcode and the word under work
   typedef struct packed {
      logic                 op;
      logic [CodeWidth-1:0] word;
   } ent_type;

   // syndrome stage payload
   typedef struct packed {
      logic                 op;
      logic [CodeWidth-1:0] word;
      logic [SynWidth-1:0]  syn;
      logic                 par;
   } syn_type;

   // result item, code_out in the lowest bits
   typedef struct packed {
      status_type           status;
      logic [DataWidth-1:0] data_out;
      logic [CodeWidth-1:0] code_out;
   } result_type;

   // spread data bits to their code word positions, parity positions zero
   function automatic logic [CodeWidth-1:0] scatter_data(input logic [DataWidth-1:0] d);
      logic [CodeWidth-1:0] w;
      w = '0;
      for (int k = 0; k < DataWidth; k++) begin
         w[DataPos[k]] = d[k];
      end
      return w;
   endfunction

   // gather data bits from their code word positions
   function automatic logic [DataWidth-1:0] extract_data(input logic [CodeWidth-1:0] w);
      logic [DataWidth-1:0] d;
      d = '0;
      for (int k = 0; k < DataWidth; k++) begin
         d[k] = w[DataPos[k]];
      end
      return d;
   endfunction

   // xor of the indices of all set bits in positions 1..15
   function automatic logic [SynWidth-1:0] syndrome(input logic [CodeWidth-1:0] w);
      logic [SynWidth-1:0] s;
      s = '0;
      for (int i = 1; i < CodeWidth; i++) begin
         if (w[i]) begin
            s = s ^ SynWidth'(i);
         end
      end
      return s;
   endfunction

endpackage

/* rtl/core/secded_ent.sv */
module secded_ent
   import secded_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  logic                 up_op,
   input  logic [DataWidth-1:0] up_data,
   input  logic [CodeWidth-1:0] up_code,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output ent_type              dn_data
);

   logic    valid_ff;
   logic    valid_in;
   ent_type data_ff;
   ent_type data_in;

   // stage takes a transfer when empty or when its content moves on
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // pick the word: scattered data for encode, received word for decode
   always_comb begin
      data_in.op   = up_op;
      data_in.word = (up_op == OP_ENCODE) ? scatter_data(up_data) : up_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

/* rtl/core/secded_syn.sv */
module secded_syn
   import secded_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  ent_type up_data,
   output logic    dn_valid,
   input  logic    dn_ready,
   output syn_type dn_data
);

   logic    valid_ff;
   logic    valid_in;
   syn_type data_ff;
   syn_type data_in;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // syndrome and overall parity of the word
   always_comb begin
      data_in.op   = up_data.op;
      data_in.word = up_data.word;
      data_in.syn  = syndrome(up_data.word);
      data_in.par  = ^up_data.word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

`ifndef SYNTHESIS
   // an encode word leaves the entry stage with all parity positions clear
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.op == OP_ENCODE |->
         !data_ff.word[0] && !data_ff.word[1] && !data_ff.word[2] &&
         !data_ff.word[4] && !data_ff.word[8])
      else $error("encode word has a parity position set before insertion");
`endif

endmodule

/* rtl/core/secded_fix.sv */
module secded_fix
   import secded_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       up_valid,
   output logic       up_ready,
   input  syn_type    up_data,
   output logic       dn_valid,
   input  logic       dn_ready,
   output result_type dn_data
);

   logic                 valid_ff;
   logic                 valid_in;
   result_type           data_ff;
   result_type           data_in;
   logic [CodeWidth-1:0] enc_word;
   logic [CodeWidth-1:0] dec_word;
   status_type           dec_status;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // encode: drop the syndrome into the parity positions, then overall parity
   always_comb begin
      enc_word    = up_data.word;
      enc_word[1] = up_data.syn[0];
      enc_word[2] = up_data.syn[1];
      enc_word[4] = up_data.syn[2];
      enc_word[8] = up_data.syn[3];
      enc_word[0] = up_data.par ^ (^up_data.syn);
   end

   // decode: correct a single error, flag parity-only and double errors
   always_comb begin
      dec_word   = up_data.word;
      dec_status = STAT_NONE;
      if (up_data.syn == '0) begin
         dec_status = up_data.par ? STAT_PARITY : STAT_NONE;
      end else if (up_data.par) begin
         dec_word   = up_data.word ^ (CodeWidth'(1) << up_data.syn);
         dec_status = STAT_SINGLE;
      end else begin
         dec_status = STAT_DOUBLE;
      end
   end

   // result formatting
   always_comb begin
      if (up_data.op == OP_ENCODE) begin
         data_in.code_out = enc_word;
         data_in.data_out = '0;
         data_in.status   = STAT_NONE;
      end else begin
         data_in.code_out = '0;
         data_in.data_out = extract_data(dec_word);
         data_in.status   = dec_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

`ifndef SYNTHESIS
   // a non-zero code word out is a proper code word
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.code_out != '0 |->
         syndrome(data_ff.code_out) == '0 && !(^data_ff.code_out))
      else $error("encoded word fails its own parity checks");

   // a non-zero code word never travels with decode fields
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.code_out != '0 |->
         data_ff.data_out == '0 && data_ff.status == STAT_NONE)
      else $error("encode result carries decode fields");

   // a transfer into a full stage only happens when its content leaves
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !dn_ready |-> !up_ready)
      else $error("final stage would overwrite a waiting result");
`endif

endmodule

/* rtl/core/secded_hamming_16_11_codec.sv */
// channel  | ports        | tdata bits (low first)                 | tuser
// req      | req_t*       | data_in[10:0], code_in[26:11], zeros   | opcode
// rsp      | rsp_t*       | code_out[15:0], data_out[26:16],       | -
//          |              | status[28:27], zeros                   |
//
// three register stages: word build, syndrome and parity, correction/insert
// one item a cycle while rsp_tready stays high; a req transfer passes the
// entry, syndrome and output registers in turn before rsp_tvalid rises
// each stage is freed as its content moves on, so a stall only backs up
// the stages behind a held result; nothing is dropped or repeated
// synchronous active-high reset clears only the stage valid bits
module secded_hamming_16_11_codec
   import secded_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // data_in[10:0], code_in[26:11], zero fill
   input  logic        req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // code_out[15:0], data_out[26:16], status[28:27]
);

   logic       ent_valid;
   logic       ent_ready;
   ent_type    ent_data;
   logic       syn_valid;
   logic       syn_ready;
   syn_type    syn_data;
   result_type res_data;

   // word build stage
   secded_ent u_ent (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_op    (req_tuser),
      .up_data  (req_tdata[10:0]),
      .up_code  (req_tdata[26:11]),
      .dn_valid (ent_valid),
      .dn_ready (ent_ready),
      .dn_data  (ent_data)
   );

   // syndrome stage
   secded_syn u_syn (
      .clock    (clock),
      .reset    (reset),
      .up_valid (ent_valid),
      .up_ready (ent_ready),
      .up_data  (ent_data),
      .dn_valid (syn_valid),
      .dn_ready (syn_ready),
      .dn_data  (syn_data)
   );

   // correction and output register stage
   secded_fix u_fix (
      .clock    (clock),
      .reset    (reset),
      .up_valid (syn_valid),
      .up_ready (syn_ready),
      .up_data  (syn_data),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_data  (res_data)
   );

   assign rsp_tdata = {3'b000, res_data};

endmodule
